// ===== hdl/stbs_pkg.sv =====
// Shared widths and controller/datapath interface types for the sorted-table search.
`default_nettype none
package stbs_pkg;
   localparam int IndexWidth = 10;
   localparam int ValueWidth = 32;
   localparam int CountWidth = 4;
   localparam int RangeWidth = IndexWidth + 2;

   localparam logic ReqLoad   = 1'b0;
   localparam logic ReqSearch = 1'b1;

   typedef struct packed {
      logic write;
      logic start;
      logic step;
      logic deliver;
   } cmd_type;

   typedef struct packed {
      logic finish;
   } sts_type;
endpackage
`default_nettype wire

// ===== hdl/stbs_ctrl.sv =====
// Sequencer for load and search items and the result handshake.
`default_nettype none
module stbs_ctrl
   import stbs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   input  wire logic    req_tuser,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output cmd_type      cmd,
   input  wire sts_type sts
);
   localparam logic StIdle  = 1'b0;
   localparam logic StProbe = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic out_free;

   assign req_tready = (state_ff == StIdle);
   assign accept     = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               if (req_tuser == ReqSearch) begin
                  cmd.start = 1'b1;
                  state_in  = StProbe;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         StProbe: begin
            if (!sts.finish) begin
               cmd.step = 1'b1;
            end else if (out_free) begin
               cmd.deliver = 1'b1;
               state_in    = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_comb begin
      if (cmd.deliver) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

// ===== hdl/stbs_dp.sv =====
// Table memory, search range registers, probe compare and result registers.
`default_nettype none
module stbs_dp
   import stbs_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [IndexWidth-1:0]        csr_wr_data,
   input  wire logic [IndexWidth-1:0]        entry_index,
   input  wire logic signed [ValueWidth-1:0] value,
   input  wire cmd_type                      cmd,
   output sts_type                           sts,
   output logic                              found,
   output logic [IndexWidth-1:0]             match_index,
   output logic [CountWidth-1:0]             probe_count
);
   localparam int AddrWidth = $clog2(TABLE_DEPTH);
   localparam int TopMax    = TABLE_DEPTH - 1;

   logic signed [ValueWidth-1:0] table_mem [TABLE_DEPTH];
   logic signed [ValueWidth-1:0] rd_data_ff;

   logic [IndexWidth-1:0]        last_index_ff;
   logic signed [ValueWidth-1:0] key_ff;
   logic signed [RangeWidth-1:0] low_ff, low_in;
   logic signed [RangeWidth-1:0] high_ff, high_in;
   logic [IndexWidth-1:0]        mid_ff, mid_in;
   logic [CountWidth-1:0]        cnt_ff;

   logic                         found_ff;
   logic [IndexWidth-1:0]        match_ff;
   logic [CountWidth-1:0]        probes_ff;

   logic [IndexWidth-1:0]        top;
   logic signed [RangeWidth-1:0] mid_ext;
   logic signed [RangeWidth-1:0] sum;
   logic                         hit;
   logic                         greater;
   logic                         empty;
   logic                         load_ok;
   logic                         rd_en;

   always_comb begin
      if (32'(last_index_ff) > TopMax) begin
         top = IndexWidth'(TopMax);
      end else begin
         top = last_index_ff;
      end
   end

   assign load_ok = (32'(entry_index) < TABLE_DEPTH);
   assign mid_ext = RangeWidth'(mid_ff);
   assign hit     = (key_ff == rd_data_ff);
   assign greater = (key_ff > rd_data_ff);

   always_comb begin
      if (greater) begin
         low_in  = mid_ext + RangeWidth'(1);
         high_in = high_ff;
      end else begin
         low_in  = low_ff;
         high_in = mid_ext - RangeWidth'(1);
      end
      sum   = low_in + high_in;
      empty = (low_in > high_in);
      if (cmd.start) begin
         mid_in = {1'b0, top[IndexWidth-1:1]};
      end else begin
         mid_in = sum[IndexWidth:1];
      end
   end

   assign sts.finish = hit | empty;
   assign rd_en      = cmd.start | cmd.step;

   always_ff @(posedge clock) begin
      if (cmd.write && load_ok) begin
         table_mem[AddrWidth'(entry_index)] <= value;
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[AddrWidth'(mid_in)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_index_ff <= IndexWidth'(1023);
      end else if (csr_wr_en) begin
         last_index_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= '0;
         cnt_ff  <= '0;
      end else if (cmd.start) begin
         low_ff  <= '0;
         high_ff <= RangeWidth'(top);
         cnt_ff  <= '0;
      end else if (cmd.step) begin
         low_ff  <= low_in;
         high_ff <= high_in;
         cnt_ff  <= cnt_ff + CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff <= value;
      end
      if (rd_en) begin
         mid_ff <= mid_in;
      end
      if (cmd.deliver) begin
         found_ff  <= hit;
         match_ff  <= hit ? mid_ff : '0;
         probes_ff <= cnt_ff + CountWidth'(1);
      end
   end

   assign found       = found_ff;
   assign match_index = match_ff;
   assign probe_count = probes_ff;
endmodule
`default_nettype wire

// ===== hdl/sorted_table_binary_search.sv =====
// Top level of the sorted-table binary search block.
//
// Usage:
//   req channel: tuser = 0 loads tdata.value into the table at tdata.entry_index,
//   tuser = 1 searches for tdata.value. Loads give no rsp item; each search gives
//   exactly one rsp item with found, match_index and probe_count.
//   csr port: csr_wr_en writes last_index, the top of every search range
//   (saturated to TABLE_DEPTH - 1); write it only while the block is idle.
// Load and search sequence:
//   A load is written as it is accepted; the next item may follow right after.
//   A search takes the item and reads the midpoint, then makes P probes, P the
//   probe count (at most 11 for 1024 entries), each comparing the registered
//   read data of the single table port and, until the search ends, issuing the
//   next read. No new item is taken until the result sits in an output register.
// Reset:
//   Synchronous, active high; clears control state and sets last_index to 1023.
//   Table contents are undefined until written.
// Stall:
//   A waiting result does not block loads or a new search; a search that ends
//   while the previous result is still held waits until rsp_tready frees it.
`default_nettype none
module sorted_table_binary_search
   import stbs_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [IndexWidth-1:0] csr_wr_data,   // last_index
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [47:0]           req_tdata,     // entry_index[9:0], value[41:10]
   input  wire logic                  req_tuser,     // req_type
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [15:0]                rsp_tdata      // found[0], match_index[10:1],
                                                     // probe_count[14:11]
);
   cmd_type                      cmd;
   sts_type                      sts;
   logic                         found;
   logic [IndexWidth-1:0]        match_index;
   logic [CountWidth-1:0]        probe_count;
   logic [IndexWidth-1:0]        entry_index;
   logic signed [ValueWidth-1:0] value;

   assign entry_index = req_tdata[IndexWidth-1:0];
   assign value       = req_tdata[IndexWidth+ValueWidth-1:IndexWidth];
   assign rsp_tdata   = {1'b0, probe_count, match_index, found};

   stbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   stbs_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .entry_index (entry_index),
      .value       (value),
      .cmd         (cmd),
      .sts         (sts),
      .found       (found),
      .match_index (match_index),
      .probe_count (probe_count)
   );
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the sorted-table binary search block.
module tb
   import stbs_pkg::*;
();

   typedef struct {
      bit                    found;
      logic [IndexWidth-1:0] where;
      logic [CountWidth-1:0] probes;
   } search_hit_type;

   class search_scoreboard;
      logic signed [ValueWidth-1:0] entries[1024];
      bit                           written[1024];
      logic [IndexWidth-1:0]        last_index;
      search_hit_type               hits_q[$];
      int                           errors;

      function new();
         last_index = 10'd1023;
         errors = 0;
      endfunction

      function void set_last_index(logic [IndexWidth-1:0] v);
         last_index = v;
      endfunction

      function int pending();
         return hits_q.size();
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 10) begin
            $display("%s", msg);
         end
      endfunction

      // walk the probe path; return the first unwritten index met, or -1
      function int walk(logic signed [ValueWidth-1:0] key, output bit hit,
                        output logic [IndexWidth-1:0] where,
                        output logic [CountWidth-1:0] probes);
         int                           lo;
         int                           hi;
         int                           mid;
         int                           gap;
         logic signed [ValueWidth-1:0] entry;
         lo = 0;
         hi = int'(last_index);
         hit = 1'b0;
         where = '0;
         probes = '0;
         gap = -1;
         do begin
            mid = (lo + hi) / 2;
            if (!written[mid] && gap < 0) begin
               gap = mid;
            end
            entry = written[mid] ? entries[mid] : '0;
            probes = probes + 1'b1;
            if (key == entry) begin
               hit = 1'b1;
               where = mid[IndexWidth-1:0];
            end else if (key > entry) begin
               lo = mid + 1;
            end else begin
               hi = mid - 1;
            end
         end while (!hit && lo <= hi);
         return gap;
      endfunction

      function void note_item(logic kind, logic [IndexWidth-1:0] idx,
                              logic signed [ValueWidth-1:0] val);
         search_hit_type        e;
         bit                    h;
         logic [IndexWidth-1:0] w;
         logic [CountWidth-1:0] p;
         if (kind == ReqLoad) begin
            entries[idx] = val;
            written[idx] = 1'b1;
         end else begin
            void'(walk(val, h, w, p));
            e.found = h;
            e.where = w;
            e.probes = p;
            hits_q.push_back(e);
         end
      endfunction

      function void check_result(logic [15:0] data);
         search_hit_type e;
         if (hits_q.size() == 0) begin
            report($sformatf("unexpected result item %h", data));
            return;
         end
         e = hits_q.pop_front();
         if (data[0] !== e.found || data[10:1] !== e.where ||
             data[14:11] !== e.probes) begin
            report($sformatf({"result mismatch: expected found=%0d index=%0d probes=%0d,",
                              " got found=%0d index=%0d probes=%0d"},
                             e.found, e.where, e.probes, data[0], data[10:1],
                             data[14:11]));
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [IndexWidth-1:0] csr_wr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [47:0]           req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [15:0]           rsp_tdata;

   search_scoreboard sb;
   int               send_idle_pct = 12;
   int               recv_idle_pct = 47;
   int               hold_left = 0;
   int               items_sent = 0;
   logic [31:0]      ladder_off;

   localparam logic signed [31:0] MinValue = 32'sh8000_0000;
   localparam logic signed [31:0] MaxValue = 32'sh7fff_ffff;

   sorted_table_binary_search i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_item(req_tuser, req_tdata[9:0], req_tdata[41:10]);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata);
         end
      end
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      #3000000;
      $display("[sorted_table_binary_search] ERROR");
      $finish;
   end

   // ascending layout spanning the full signed range
   function automatic logic signed [31:0] ladder_value(int i);
      if (i == 0) begin
         return MinValue;
      end
      if (i == 1023) begin
         return MaxValue;
      end
      return $signed(32'h8000_0000 + (32'(i) << 22) + ladder_off);
   endfunction

   task automatic send_item(logic kind, logic [IndexWidth-1:0] idx,
                            logic signed [ValueWidth-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {6'd0, val, idx};
      do @(posedge clock); while (req_tready !== 1'b1);
      @(negedge clock);
      items_sent++;
   endtask

   // fill every unwritten entry on the probe path, then search
   task automatic search_for(logic signed [ValueWidth-1:0] key);
      int                    gap;
      bit                    h;
      logic [IndexWidth-1:0] w;
      logic [CountWidth-1:0] p;
      gap = sb.walk(key, h, w, p);
      while (gap >= 0) begin
         send_item(ReqLoad, gap[IndexWidth-1:0], ladder_value(gap));
         gap = sb.walk(key, h, w, p);
      end
      send_item(ReqSearch, IndexWidth'($urandom_range(1023)), key);
   endtask

   task automatic set_last_index(logic [IndexWidth-1:0] v);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) begin
         @(negedge clock);
      end
      repeat (16) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.set_last_index(v);
   endtask

   task automatic random_item();
      int                           r;
      int                           i;
      int                           top;
      logic signed [ValueWidth-1:0] key;
      r = $urandom_range(99);
      top = int'(sb.last_index);
      i = $urandom_range(top);
      if (r < 30) begin
         if ($urandom_range(4) == 0) begin
            i = $urandom_range(1023);
         end
         send_item(ReqLoad, i[IndexWidth-1:0], ladder_value(i));
      end else if (r < 38) begin
         send_item(ReqLoad, i[IndexWidth-1:0], $urandom);
      end else begin
         case ($urandom_range(9))
            0, 1, 2, 3: key = ladder_value(i);
            4: key = ladder_value(i) + 1;
            5, 6: key = $urandom;
            7: begin
               case ($urandom_range(3))
                  0: key = MinValue;
                  1: key = MaxValue;
                  2: key = '0;
                  default: key = -1;
               endcase
            end
            default: key = sb.written[i] ? sb.entries[i] : ladder_value(i);
         endcase
         search_for(key);
      end
   endtask

   initial begin
      int limits[8];
      int target;
      int guard;
      sb = new();
      ladder_off = $urandom_range(4194302, 1);
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = ReqLoad;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_last_index(10'd0);
      send_item(ReqLoad, 10'd0, 32'sd5);
      search_for(32'sd3);
      search_for(32'sd5);
      search_for(32'sd9);
      send_item(ReqLoad, 10'd0, MinValue);
      search_for(MinValue);
      set_last_index(10'd1);
      search_for(ladder_value(1));
      set_last_index(10'd1023);
      send_item(ReqLoad, 10'd1023, MaxValue);
      search_for(MaxValue);
      search_for(32'sd0);

      limits = '{5, 1023, 37, 0, 0, 200, 1023, 12};
      limits[3] = $urandom_range(1023);
      for (int seg = 0; seg < 8; seg++) begin
         if (seg < 3) begin
            send_idle_pct = 12;
            recv_idle_pct = 47;
         end else if (seg < 6) begin
            send_idle_pct = 47;
            recv_idle_pct = 12;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         set_last_index(limits[seg][IndexWidth-1:0]);
         if (seg == 6) begin
            hold_left = 400;
         end
         target = items_sent + 125;
         while (items_sent < target) begin
            random_item();
         end
      end

      req_tvalid <= 1'b0;
      guard = 0;
      while (sb.pending() != 0 && guard < 50000) begin
         @(negedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.report($sformatf("%0d search results never arrived", sb.pending()));
      end
      if (sb.errors == 0) begin
         $display("[sorted_table_binary_search] OK");
      end else begin
         $display("[sorted_table_binary_search] ERROR");
      end
      $finish;
   end
endmodule
